[design/sha256_message_hasher_macros.svh]
// Assertion macros for the hasher.
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define SHA_ASSERT(label, clk, rst_n, prop)
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[design/sha_pkg.sv]
package sha_pkg;
	localparam logic REQ_DATA   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} sha_req_t;

	typedef struct packed {
		logic [63:0] digest_part;
		logic [1:0]  part_index;
		logic        last_part;
	} sha_rsp_t;
endpackage

[design/sha_if.sv]
interface sha_req_if;
	import sha_pkg::*;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;
	modport source (output valid, req_type, data_byte, input ready);
	modport sink (input valid, req_type, data_byte, output ready);
endinterface

interface sha_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part;
	logic [1:0]  part_index;
	logic        last_part;
	modport source (output valid, digest_part, part_index, last_part, input ready);
	modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface

[design/sha_fifo.sv]
// Two-entry request queue between front and back.
module sha_fifo import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sha_req_t push_data,
	output logic     full,
	input  logic     pop,
	output sha_req_t pop_data,
	output logic     empty
);
	sha_req_t   mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && !empty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule

[design/sha_core.sv]
// Back end: block bytes gather in the schedule window, padding, 64-round compression,
// digest output.
module sha_core import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  sha_req_t req,
	output logic     req_pop,
	sha_rsp_if.source rsp
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] hash_q [8];
	logic [31:0] w_q [16];      // block bytes, big-endian words, then schedule
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic        fin_q;     // finishing: after compression pad more or emit
	logic        len_blk_q; // current padded block carries the bit length
	logic [1:0]  part_q;
	logic [63:0] part_q_data;

	// padding byte for the current fill position
	logic [7:0] pad_byte;
	always_comb begin
		if (fill_q >= 6'd56 && len_blk_q && fin_q)
			pad_byte = bits_q[8'(6'd63 - fill_q) * 8 +: 8];
		else
			pad_byte = 8'h00;
	end

	// round logic
	logic [31:0] w2, w7, w15, w16, s0, s1, wn, wr, t1, t2, e, a;
	always_comb begin
		w2  = w_q[4'(rnd_q - 6'd2)];
		w7  = w_q[4'(rnd_q - 6'd7)];
		w15 = w_q[4'(rnd_q - 6'd15)];
		w16 = w_q[rnd_q[3:0]];
		s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		wn  = s1 + w7 + s0 + w16;
		wr  = (rnd_q >= 6'd16) ? wn : w16;
		e   = v_q[4];
		a   = v_q[0];
		t1  = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + wr;
		t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign req_pop = state_q == ST_IDLE && req_valid;
	assign part_q_data = {hash_q[{part_q, 1'b0}], hash_q[{part_q, 1'b1}]};
	assign rsp.valid = state_q == ST_OUT;
	assign rsp.digest_part = part_q_data;
	assign rsp.part_index = part_q;
	assign rsp.last_part = part_q == 2'd3;

	always_ff @(posedge clk) begin
		// byte lane: fill position 0 of a word lands in bits 31:24
		if (req_pop && req.req_type == REQ_DATA)
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= req.data_byte;
		else if (req_pop)
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= 8'h80;
		else if (state_q == ST_PAD)
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= pad_byte;
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end else if (state_q == ST_ROUND) begin
			w_q[rnd_q[3:0]] <= wr;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= 6'd0;
			bits_q    <= 64'd0;
			rnd_q     <= 6'd0;
			fin_q     <= 1'b0;
			len_blk_q <= 1'b0;
			part_q    <= 2'd0;
			for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_pop) begin
						fill_q <= fill_q + 6'd1;
						if (req.req_type == REQ_DATA) begin
							bits_q <= bits_q + 64'd8;
							if (fill_q == 6'd63) state_q <= ST_LOAD;
						end else begin
							fin_q     <= 1'b1;
							// marker at 56 or later spills the length into an extra block
							len_blk_q <= fill_q < 6'd56;
							state_q   <= (fill_q == 6'd63) ? ST_LOAD : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					rnd_q   <= 6'd0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					if (!fin_q) state_q <= ST_IDLE;
					else if (len_blk_q) begin
						state_q <= ST_OUT;
						part_q  <= 2'd0;
					end else begin
						len_blk_q <= 1'b1;
						state_q   <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							state_q   <= ST_IDLE;
							fin_q     <= 1'b0;
							len_blk_q <= 1'b0;
							bits_q    <= 64'd0;
							fill_q    <= 6'd0;
							for (int i = 0; i < 8; i++) hash_q[i] <= INIT_HASH[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/sha256_message_hasher.sv]
// SHA-256 message hasher.
// Channel in (sha_req_if sink): one request per byte, req_type 0 carries
// data_byte, req_type 1 finishes the message.
// Channel out (sha_rsp_if source): four results per finish, digest_part
// big-endian H0:H1 first, part_index 0..3, last_part on the fourth.
// A two-entry queue takes requests while the back end compresses.
// Flow: the core takes data bytes while idle; after the 64th byte of a block
// it runs load, 64 rounds at one per cycle in the shared round unit, then add.
// A finish pads one byte per cycle to the block end, compresses, possibly
// pads and compresses a second block, then shows 4 parts.
// Reset: hash words load the standard initial values, counters clear,
// queue empties. Output stall holds the current part; input backs up
// into the queue, then ready drops.
module sha256_message_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sha_req_if.sink   in_req,
	sha_rsp_if.source out_rsp
);
	`include "sha256_message_hasher_macros.svh"

	sha_req_t push_data, pop_data;
	logic     full, empty, pop;

	assign push_data    = '{req_type: in_req.req_type, data_byte: in_req.data_byte};
	assign in_req.ready = !full;

	sha_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(in_req.valid), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.req_valid(!empty), .req(pop_data), .req_pop(pop),
		.rsp(out_rsp)
	);

	`SHA_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`SHA_ASSERT(a_last_idx, clk, arst_n, out_rsp.valid && out_rsp.last_part |-> out_rsp.part_index == 2'd3)
	`SHA_ASSERT(a_no_pop_out, clk, arst_n, out_rsp.valid |-> !pop)
endmodule
